// ===== rtl/tnsgd_pkg.sv =====
// tnsgd_pkg: shared types, constants and helpers of the tanh neuron sgd trainer
// used by every file in rtl/, depends on nothing

package tnsgd_pkg;

  localparam int NUM_FEATURES_DEF = 4096;
  localparam int LANES_DEF        = 32;
  localparam int TANH_ENTRIES_DEF = 1024;
  localparam int CHUNK_BITS       = 32;
  localparam int WEIGHT_W         = 16;
  localparam int SUM_W            = 32;
  localparam int LR_W             = 15;
  localparam int TAB_W            = 15;

  localparam logic [LR_W-1:0]            LR_RESET = 15'd19661;
  localparam logic signed [WEIGHT_W-1:0] IW_RESET = 16'sd0;

  typedef enum logic [1:0] {
    OP_PREDICT = 2'd0,
    OP_TRAIN   = 2'd1,
    OP_FILL    = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic {
    REG_LEARNING_RATE  = 1'b0,
    REG_INITIAL_WEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_RD, ST_SUM, ST_ACC, ST_ACT, ST_ROM, ST_TLU,
    ST_MA, ST_MB, ST_MC, ST_MD, ST_ME, ST_TRD, ST_TWR, ST_OUT
  } state_t;

  typedef struct packed {
    logic wr_fill;
    logic wr_upd;
    logic bit_set;
  } lane_ctl_t;

  // shift-subtract divider, elaboration time only
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

// ===== rtl/tanh_neuron_sgd_trainer.sv =====
// each stored chunk is accepted, then makes ceil(32/LANES) lane passes (one at defaults),
// each through the read, sum and accumulate states; a last chunk then runs the tanh
// lookup (act, rom, tlu) and output states, a train sample also the delta multiplies
// (ma to me) and a read and a write state per stored weight row (bank read-modify-write
// port). one word is in flight at a time. reset and the fill opcode sweep all weight rows,
// one row per cycle (128 at defaults), with the input stalled; config is taken anytime.

module tanh_neuron_sgd_trainer #(
  parameter int NUM_FEATURES = tnsgd_pkg::NUM_FEATURES_DEF,
  parameter int LANES        = tnsgd_pkg::LANES_DEF,
  parameter int TANH_ENTRIES = tnsgd_pkg::TANH_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_feature_bits,
  input  logic        in_label,
  input  logic        in_last_chunk,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] out_activation,
  output logic        out_predicted_class,
  output logic        out_was_trained,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int CB   = tnsgd_pkg::CHUNK_BITS;
  localparam int NC   = (NUM_FEATURES + CB - 1) / CB;
  localparam int P    = (CB + LANES - 1) / LANES;
  localparam int ROWS = NC * P;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RCW  = $clog2(ROWS + 1);
  localparam int CAW  = (NC > 1) ? $clog2(NC) : 1;
  localparam int CIW  = $clog2(NC + 1);
  localparam int PW   = (P > 1) ? $clog2(P) : 1;
  localparam int IW   = $clog2(TANH_ENTRIES + 1);
  localparam int WW   = tnsgd_pkg::WEIGHT_W;
  localparam int SW   = tnsgd_pkg::SUM_W;

  tnsgd_pkg::state_t state_r, state_nxt;

  logic [tnsgd_pkg::LR_W-1:0] lr_r;
  logic signed [WW-1:0]       iw_r;
  logic signed [WW-1:0]       fill_val_r;
  logic [RW-1:0]              row_r;
  logic [RCW-1:0]             acc_row_r;
  logic [CIW-1:0]             chunk_idx_r;
  logic [PW-1:0]              pass_r;
  logic [CAW-1:0]             tr_c_r;
  logic [PW-1:0]              tr_p_r;
  logic signed [SW-1:0]       sum_r;
  logic [31:0]                bits_r;
  logic [31:0]                st_q_r;
  logic                       train_r, pos_r, last_r, neg_r;
  logic [IW-1:0]              idx_r;
  logic signed [WW-1:0]       act_r;
  logic [30:0]                sq_r;
  logic [16:0]                emag_r;
  logic                       eneg_r;
  logic [31:0]                prod_r;
  logic [30:0]                om_r;
  logic [47:0]                pl_r;
  logic [46:0]                ph_r;
  logic signed [WW-1:0]       delta_r;
  logic                       out_valid_r;
  logic signed [WW-1:0]       out_act_r;
  logic                       out_cls_r, out_trn_r;

  logic [31:0] fs_mem [NC];

  logic                       in_acc;
  tnsgd_pkg::opcode_t         op;
  logic [LANES-1:0]           lane_bit;
  tnsgd_pkg::lane_ctl_t       lane_ctl [LANES];
  logic signed [WW-1:0]       lane_val [LANES];
  logic [RW-1:0]              rd_addr;
  logic signed [SW-1:0]       merge_sum;
  logic [tnsgd_pkg::TAB_W-1:0] tab_q;
  logic [31:0]                sel_word;
  logic [CAW-1:0]             sel_c;
  logic [PW-1:0]              sel_p;
  logic [SW-1:0]              mabs;
  logic [15:0]                mclamp;
  logic [31:0]                idx_full;
  logic signed [17:0]         err;
  logic [62:0]                pfull;
  logic [14:0]                dmag;
  logic                       out_load;

  assign op       = tnsgd_pkg::opcode_t'(in_opcode);
  assign in_stall = (state_r != tnsgd_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == tnsgd_pkg::ST_OUT) && (!out_valid_r || !out_stall);
  assign rd_addr  = (state_r == tnsgd_pkg::ST_TRD) ? row_r : acc_row_r[RW-1:0];

  assign out_valid           = out_valid_r;
  assign out_activation      = out_act_r;
  assign out_predicted_class = out_cls_r;
  assign out_was_trained     = out_trn_r;

  // lane bit selection for the accumulate and update passes
  always_comb begin
    int pos;
    int feat;
    if (state_r == tnsgd_pkg::ST_TWR) begin
      sel_word = st_q_r;
      sel_c    = tr_c_r;
      sel_p    = tr_p_r;
    end else begin
      sel_word = bits_r;
      sel_c    = chunk_idx_r[CAW-1:0];
      sel_p    = pass_r;
    end
    for (int l = 0; l < LANES; l++) begin
      pos  = int'(sel_p) * LANES + l;
      feat = int'(sel_c) * CB + pos;
      lane_bit[l] = (pos < CB) && (feat < NUM_FEATURES) && sel_word[pos[4:0]];
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_ctl[l].wr_fill = (state_r == tnsgd_pkg::ST_CLR);
      lane_ctl[l].wr_upd  = (state_r == tnsgd_pkg::ST_TWR);
      lane_ctl[l].bit_set = lane_bit[l];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    tnsgd_lane #(.ROWS(ROWS), .RW(RW)) u_lane (
      .clk      (clk),
      .ctl      (lane_ctl[l]),
      .rd_addr  (rd_addr),
      .wr_addr  (row_r),
      .fill_val (fill_val_r),
      .delta    (delta_r),
      .contrib  (lane_val[l])
    );
  end

  tnsgd_merge #(.LANES(LANES)) u_merge (
    .clk   (clk),
    .vals  (lane_val),
    .sum_r (merge_sum)
  );

  tnsgd_tanh_rom #(.TANH_ENTRIES(TANH_ENTRIES), .IW(IW)) u_rom (
    .clk    (clk),
    .idx    (idx_r),
    .data_r (tab_q)
  );

  // datapath arithmetic
  always_comb begin
    mabs     = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
    mclamp   = (mabs > 32'd32768) ? 16'd32768 : mabs[15:0];
    idx_full = ({16'd0, mclamp} * 32'(TANH_ENTRIES)) >> 15;
    err      = {{2{act_r[WW-1]}}, act_r} - (pos_r ? 18'sd32768 : -18'sd32768);
    pfull    = 63'(pl_r) + (63'(ph_r) << 16);
    dmag     = 15'((pfull + (63'd1 << 47)) >> 48);
  end

  always_ff @(posedge clk) begin
    if (in_acc && (op == tnsgd_pkg::OP_PREDICT || op == tnsgd_pkg::OP_TRAIN)
        && (chunk_idx_r < CIW'(NC))) begin
      fs_mem[chunk_idx_r[CAW-1:0]] <= in_feature_bits;
    end
    st_q_r <= fs_mem[tr_c_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= tnsgd_pkg::LR_RESET;
      iw_r <= tnsgd_pkg::IW_RESET;
    end else if (cfg_we) begin
      unique case (tnsgd_pkg::cfg_reg_t'(cfg_index))
        tnsgd_pkg::REG_LEARNING_RATE:  lr_r <= cfg_wdata[tnsgd_pkg::LR_W-1:0];
        tnsgd_pkg::REG_INITIAL_WEIGHT: iw_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tnsgd_pkg::ST_CLR: begin
        if (row_r == RW'(ROWS - 1)) state_nxt = tnsgd_pkg::ST_IDLE;
      end
      tnsgd_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (op == tnsgd_pkg::OP_FILL) begin
            state_nxt = tnsgd_pkg::ST_CLR;
          end else if (op != tnsgd_pkg::OP_NONE) begin
            if (chunk_idx_r < CIW'(NC)) state_nxt = tnsgd_pkg::ST_RD;
            else if (in_last_chunk) state_nxt = tnsgd_pkg::ST_ACT;
          end
        end
      end
      tnsgd_pkg::ST_RD:  state_nxt = tnsgd_pkg::ST_SUM;
      tnsgd_pkg::ST_SUM: state_nxt = tnsgd_pkg::ST_ACC;
      tnsgd_pkg::ST_ACC: begin
        if (pass_r != PW'(P - 1)) state_nxt = tnsgd_pkg::ST_RD;
        else if (last_r) state_nxt = tnsgd_pkg::ST_ACT;
        else state_nxt = tnsgd_pkg::ST_IDLE;
      end
      tnsgd_pkg::ST_ACT: state_nxt = tnsgd_pkg::ST_ROM;
      tnsgd_pkg::ST_ROM: state_nxt = tnsgd_pkg::ST_TLU;
      tnsgd_pkg::ST_TLU: state_nxt = train_r ? tnsgd_pkg::ST_MA : tnsgd_pkg::ST_OUT;
      tnsgd_pkg::ST_MA:  state_nxt = tnsgd_pkg::ST_MB;
      tnsgd_pkg::ST_MB:  state_nxt = tnsgd_pkg::ST_MC;
      tnsgd_pkg::ST_MC:  state_nxt = tnsgd_pkg::ST_MD;
      tnsgd_pkg::ST_MD:  state_nxt = tnsgd_pkg::ST_ME;
      tnsgd_pkg::ST_ME: begin
        state_nxt = (acc_row_r != '0) ? tnsgd_pkg::ST_TRD : tnsgd_pkg::ST_OUT;
      end
      tnsgd_pkg::ST_TRD: state_nxt = tnsgd_pkg::ST_TWR;
      tnsgd_pkg::ST_TWR: begin
        if (RCW'(row_r) + RCW'(1) == acc_row_r) state_nxt = tnsgd_pkg::ST_OUT;
        else state_nxt = tnsgd_pkg::ST_TRD;
      end
      tnsgd_pkg::ST_OUT: begin
        if (out_load) state_nxt = tnsgd_pkg::ST_IDLE;
      end
      default: state_nxt = tnsgd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tnsgd_pkg::ST_CLR;
      row_r       <= '0;
      fill_val_r  <= '0;
      acc_row_r   <= '0;
      chunk_idx_r <= '0;
      pass_r      <= '0;
      tr_c_r      <= '0;
      tr_p_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall && !out_load) out_valid_r <= 1'b0;
      unique case (state_r)
        tnsgd_pkg::ST_CLR: row_r <= row_r + RW'(1);
        tnsgd_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (op == tnsgd_pkg::OP_FILL) begin
              fill_val_r  <= iw_r;
              row_r       <= '0;
              acc_row_r   <= '0;
              chunk_idx_r <= '0;
              sum_r       <= '0;
            end else if (op != tnsgd_pkg::OP_NONE) begin
              train_r <= (op == tnsgd_pkg::OP_TRAIN);
              pos_r   <= in_label;
              last_r  <= in_last_chunk;
              bits_r  <= in_feature_bits;
              pass_r  <= '0;
            end
          end
        end
        tnsgd_pkg::ST_ACC: begin
          sum_r     <= sum_r + merge_sum;
          acc_row_r <= acc_row_r + RCW'(1);
          if (pass_r == PW'(P - 1)) begin
            chunk_idx_r <= chunk_idx_r + CIW'(1);
          end else begin
            pass_r <= pass_r + PW'(1);
          end
        end
        tnsgd_pkg::ST_ACT: begin
          neg_r <= sum_r[SW-1];
          idx_r <= idx_full[IW-1:0];
        end
        tnsgd_pkg::ST_TLU: begin
          act_r <= neg_r ? -$signed({1'b0, tab_q}) : $signed({1'b0, tab_q});
        end
        tnsgd_pkg::ST_MA: begin
          sq_r   <= 31'($signed(act_r) * $signed(act_r));
          eneg_r <= err[17];
          emag_r <= err[17] ? 17'(-err) : err[16:0];
        end
        tnsgd_pkg::ST_MB: begin
          prod_r <= {17'd0, lr_r} * {15'd0, emag_r};
          om_r   <= (31'd1 << 30) - sq_r;
        end
        tnsgd_pkg::ST_MC: pl_r <= {16'd0, prod_r} * {32'd0, om_r[15:0]};
        tnsgd_pkg::ST_MD: ph_r <= {15'd0, prod_r} * {32'd0, om_r[30:16]};
        tnsgd_pkg::ST_ME: begin
          delta_r <= eneg_r ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
          row_r   <= '0;
          tr_c_r  <= '0;
          tr_p_r  <= '0;
        end
        tnsgd_pkg::ST_TWR: begin
          row_r <= row_r + RW'(1);
          if (tr_p_r == PW'(P - 1)) begin
            tr_p_r <= '0;
            tr_c_r <= tr_c_r + CAW'(1);
          end else begin
            tr_p_r <= tr_p_r + PW'(1);
          end
        end
        tnsgd_pkg::ST_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_act_r   <= act_r;
            out_cls_r   <= !act_r[WW-1];
            out_trn_r   <= train_r;
            acc_row_r   <= '0;
            chunk_idx_r <= '0;
            sum_r       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tnsgd_pkg::ST_TRD |-> RCW'(row_r) < acc_row_r)
    else $error("update row past stored rows");

  a_chunk_sat: assert property (@(posedge clk) disable iff (!rst_n)
    chunk_idx_r <= CIW'(NC))
    else $error("chunk index beyond store depth");

  a_row_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tnsgd_pkg::ST_IDLE |-> acc_row_r == RCW'(int'(chunk_idx_r) * P))
    else $error("row count out of step with chunk index");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tnsgd_pkg::ST_OUT && out_valid_r && out_stall |=> state_r == tnsgd_pkg::ST_OUT)
    else $error("result word overwritten while stalled");

endmodule

// ===== rtl/tnsgd_lane.sv =====
// tnsgd_lane: one weight bank lane, masked read for the sum and saturating update
// depends on tnsgd_pkg

module tnsgd_lane #(
  parameter int ROWS = tnsgd_pkg::NUM_FEATURES_DEF / tnsgd_pkg::CHUNK_BITS,
  parameter int RW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                                 clk,
  input  tnsgd_pkg::lane_ctl_t                 ctl,
  input  logic [RW-1:0]                        rd_addr,
  input  logic [RW-1:0]                        wr_addr,
  input  logic signed [tnsgd_pkg::WEIGHT_W-1:0] fill_val,
  input  logic signed [tnsgd_pkg::WEIGHT_W-1:0] delta,
  output logic signed [tnsgd_pkg::WEIGHT_W-1:0] contrib
);

  logic signed [tnsgd_pkg::WEIGHT_W-1:0] mem [ROWS];
  logic signed [tnsgd_pkg::WEIGHT_W-1:0] rdata_r;
  logic signed [tnsgd_pkg::WEIGHT_W+1:0] diff;
  logic signed [tnsgd_pkg::WEIGHT_W-1:0] upd_val;

  always_comb begin
    diff = {{2{rdata_r[tnsgd_pkg::WEIGHT_W-1]}}, rdata_r}
         - {{2{delta[tnsgd_pkg::WEIGHT_W-1]}}, delta};
    if (diff > 18'sd32767) begin
      upd_val = 16'sh7fff;
    end else if (diff < -18'sd32768) begin
      upd_val = 16'sh8000;
    end else begin
      upd_val = diff[tnsgd_pkg::WEIGHT_W-1:0];
    end
    contrib = ctl.bit_set ? rdata_r : '0;
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (ctl.wr_fill) begin
      mem[wr_addr] <= fill_val;
    end else if (ctl.wr_upd && ctl.bit_set) begin
      mem[wr_addr] <= upd_val;
    end
  end

endmodule

// ===== rtl/tnsgd_merge.sv =====
// tnsgd_merge: registered adder tree that merges the lane contributions
// depends on tnsgd_pkg

module tnsgd_merge #(
  parameter int LANES = tnsgd_pkg::LANES_DEF
) (
  input  logic                                 clk,
  input  logic signed [tnsgd_pkg::WEIGHT_W-1:0] vals [LANES],
  output logic signed [tnsgd_pkg::SUM_W-1:0]    sum_r
);

  localparam int LVL = (LANES > 1) ? $clog2(LANES) : 0;
  localparam int N2  = 1 << LVL;

  logic signed [tnsgd_pkg::SUM_W-1:0] node [LVL+1][N2];

  always_comb begin
    for (int lv = 0; lv <= LVL; lv++) begin
      for (int i = 0; i < N2; i++) begin
        node[lv][i] = '0;
      end
    end
    for (int i = 0; i < LANES; i++) begin
      node[0][i] = tnsgd_pkg::SUM_W'(vals[i]);
    end
    for (int lv = 1; lv <= LVL; lv++) begin
      for (int i = 0; i < (N2 >> lv); i++) begin
        node[lv][i] = node[lv-1][2*i] + node[lv-1][2*i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= node[LVL][0];
  end

endmodule

// ===== rtl/tnsgd_tanh_rom.sv =====
// tnsgd_tanh_rom: tanh lookup table built at elaboration, registered read
// depends on tnsgd_pkg (udiv)

module tnsgd_tanh_rom #(
  parameter int TANH_ENTRIES = tnsgd_pkg::TANH_ENTRIES_DEF,
  parameter int IW           = $clog2(TANH_ENTRIES + 1)
) (
  input  logic                              clk,
  input  logic [IW-1:0]                     idx,
  output logic [tnsgd_pkg::TAB_W-1:0]       data_r
);

  typedef logic [tnsgd_pkg::TAB_W-1:0] tab_t [TANH_ENTRIES+1];

  localparam logic [63:0] ONE = 64'h1_0000_0000;

  function automatic tab_t build_tab();
    tab_t        tb;
    logic [63:0] a, r, term, q, num, den, t;
    logic [127:0] pr;
    a    = tnsgd_pkg::udiv(64'd16 << 32, 64'(TANH_ENTRIES));
    r    = ONE;
    term = ONE;
    q    = ONE;
    for (int k = 1; k <= 16; k++) begin
      pr   = {64'd0, term} * {64'd0, a};
      term = tnsgd_pkg::udiv(pr[95:32], 64'(k));
      if (k % 2 == 1) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    for (int i = 0; i <= TANH_ENTRIES; i++) begin
      num = (ONE - q) << 15;
      den = ONE + q;
      t   = tnsgd_pkg::udiv(num + (den >> 1), den);
      tb[i] = (t > 64'd32767) ? 15'h7fff : t[tnsgd_pkg::TAB_W-1:0];
      pr  = {64'd0, q} * {64'd0, r} + 128'h8000_0000;
      q   = pr[95:32];
    end
    return tb;
  endfunction

  localparam tab_t TAB = build_tab();

  always_ff @(posedge clk) begin
    data_r <= TAB[idx];
  end

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for tanh_neuron_sgd_trainer, runs directed rows then random samples
// keeps its own neuron model (weights, tanh table, sgd update); depends on the rtl/ files
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFEAT = 4096;
  localparam int NCHUNK = NFEAT / tnsgd_pkg::CHUNK_BITS;
  localparam int TAB_N = 1024;
  localparam int SETTLE = 400;

  typedef struct {
    logic signed [15:0] act;
    bit cls;
    bit tr;
  } result_t;

  typedef struct {
    bit is_cfg;
    tnsgd_pkg::cfg_reg_t reg_sel;
    logic [15:0] wdata;
    tnsgd_pkg::opcode_t op;
    logic [31:0] bits;
    bit lbl;
    bit last;
    bit typed;
    result_t res;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic [31:0] in_feature_bits = '0;
  logic in_label = 0;
  logic in_last_chunk = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] out_activation;
  logic out_predicted_class;
  logic out_was_trained;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [15:0] cfg_wdata = '0;

  tanh_neuron_sgd_trainer dut (.*);

  always #1 clk = ~clk;

  // neuron model state
  shortint weights[NFEAT];
  logic [31:0] chunk_store[NCHUNK];
  longint acc_sum;
  int chunk_pos;
  int unsigned rate;
  shortint fill_value;
  int unsigned tanh_lut[TAB_N + 1];

  result_t pending_results[$];
  int errors = 0;
  int burst_left = 0;
  int words_sent = 0;

  function automatic void build_tanh();
    longint unsigned a, r, term, q, num, den, t;
    a = (longint'(16) << 32) / TAB_N;
    r = 64'h1_0000_0000;
    term = r;
    q = r;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * a) >> 32) / k;
      if (k % 2) r -= term;
      else r += term;
    end
    for (int i = 0; i <= TAB_N; i++) begin
      num = (64'h1_0000_0000 - q) << 15;
      den = 64'h1_0000_0000 + q;
      t = (num + den / 2) / den;
      tanh_lut[i] = (t > 32767) ? 32767 : int'(t);
      q = (q * r + (64'h1 << 31)) >> 32;
    end
  endfunction

  function automatic void clear_sample();
    foreach (chunk_store[c]) chunk_store[c] = '0;
    acc_sum = 0;
    chunk_pos = 0;
  endfunction

  function automatic void neuron_reset();
    foreach (weights[i]) weights[i] = 0;
    clear_sample();
    rate = tnsgd_pkg::LR_RESET;
    fill_value = tnsgd_pkg::IW_RESET;
    build_tanh();
  endfunction

  function automatic void sgd_update(longint act, bit lbl);
    longint err, emag, om, delta, w;
    longint unsigned p;
    err = act - (lbl ? 32768 : -32768);
    emag = err < 0 ? -err : err;
    om = (longint'(1) << 30) - act * act;
    p = longint'(rate) * emag * om;
    delta = longint'((p + (64'h1 << 47)) >> 48);
    if (err < 0) delta = -delta;
    for (int c = 0; c < NCHUNK; c++)
      for (int b = 0; b < tnsgd_pkg::CHUNK_BITS; b++)
        if (chunk_store[c][b]) begin
          w = longint'(weights[c * tnsgd_pkg::CHUNK_BITS + b]) - delta;
          if (w > 32767) w = 32767;
          if (w < -32768) w = -32768;
          weights[c * tnsgd_pkg::CHUNK_BITS + b] = shortint'(w);
        end
  endfunction

  function automatic bit neuron_step(tnsgd_pkg::opcode_t op, logic [31:0] bits, bit lbl,
                                     bit last, output result_t r);
    longint m, act;
    r = '{0, 0, 0};
    if (op == tnsgd_pkg::OP_NONE) return 0;
    if (op == tnsgd_pkg::OP_FILL) begin
      foreach (weights[i]) weights[i] = fill_value;
      clear_sample();
      return 0;
    end
    if (chunk_pos < NCHUNK) begin
      chunk_store[chunk_pos] = bits;
      for (int b = 0; b < tnsgd_pkg::CHUNK_BITS; b++)
        if (bits[b]) acc_sum += weights[chunk_pos * tnsgd_pkg::CHUNK_BITS + b];
      chunk_pos++;
    end
    if (!last) return 0;
    m = acc_sum < 0 ? -acc_sum : acc_sum;
    if (m > 32768) m = 32768;
    act = tanh_lut[m >> 5];
    if (acc_sum < 0) act = -act;
    if (op == tnsgd_pkg::OP_TRAIN) sgd_update(act, lbl);
    r.act = act[15:0];
    r.cls = act >= 0;
    r.tr = op == tnsgd_pkg::OP_TRAIN;
    clear_sample();
    return 1;
  endfunction

  task automatic send_word(tnsgd_pkg::opcode_t op, logic [31:0] bits, bit lbl, bit last,
                           bit typed = 0, result_t typed_res = '{0, 0, 0});
    result_t r;
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_opcode = op;
    in_feature_bits = bits;
    in_label = lbl;
    in_last_chunk = last;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    if (neuron_step(op, bits, lbl, last, r)) pending_results.push_back(typed ? typed_res : r);
    if (op != tnsgd_pkg::OP_NONE) words_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    wait (pending_results.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(tnsgd_pkg::cfg_reg_t sel, logic [15:0] data);
    drain();
    @(negedge clk);
    cfg_we = 1;
    cfg_index = sel;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 0;
    if (sel == tnsgd_pkg::REG_LEARNING_RATE) rate = data[14:0];
    else fill_value = shortint'(data);
  endtask

  function automatic row_t word_row(tnsgd_pkg::opcode_t op, logic [31:0] bits, bit lbl,
                                    bit last);
    return '{0, tnsgd_pkg::REG_LEARNING_RATE, '0, op, bits, lbl, last, 0, '{0, 0, 0}};
  endfunction

  function automatic row_t typed_row(tnsgd_pkg::opcode_t op, logic [31:0] bits, bit lbl,
                                     logic signed [15:0] act, bit cls, bit tr);
    return '{0, tnsgd_pkg::REG_LEARNING_RATE, '0, op, bits, lbl, 1, 1, '{act, cls, tr}};
  endfunction

  function automatic row_t cfg_row(tnsgd_pkg::cfg_reg_t sel, logic [15:0] data);
    return '{1, sel, data, tnsgd_pkg::OP_PREDICT, '0, 0, 0, 0, '{0, 0, 0}};
  endfunction

  function automatic logic [31:0] rand_bits();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return 32'h1 << $urandom_range(0, 31);
      2: return $urandom() & $urandom() & $urandom();
      default: return $urandom();
    endcase
  endfunction

  // receiver stall pattern
  int stall_mode = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= $urandom_range(0, 1);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_activation !== e.act) begin
          $error("activation: expected %0d got %0d", e.act, out_activation);
          errors++;
        end
        if (out_predicted_class !== e.cls) begin
          $error("predicted_class: expected %0d got %0d", e.cls, out_predicted_class);
          errors++;
        end
        if (out_was_trained !== e.tr) begin
          $error("was_trained: expected %0d got %0d", e.tr, out_was_trained);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    row_t rows[$];
    tnsgd_pkg::opcode_t op;
    int n;
    bit lbl;
    neuron_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    rows.push_back(typed_row(tnsgd_pkg::OP_PREDICT, '1, 0, 16'sd0, 1, 0));
    rows.push_back(typed_row(tnsgd_pkg::OP_TRAIN, '1, 1, 16'sd0, 1, 1));
    rows.push_back(typed_row(tnsgd_pkg::OP_PREDICT, '0, 1, 16'sd0, 1, 0));
    rows.push_back(word_row(tnsgd_pkg::OP_NONE, '1, 1, 1));
    rows.push_back(word_row(tnsgd_pkg::OP_TRAIN, 32'hA5A5_5A5A, 1, 0));
    rows.push_back(word_row(tnsgd_pkg::OP_PREDICT, 32'h0000_FFFF, 0, 1));
    rows.push_back(word_row(tnsgd_pkg::OP_PREDICT, 32'h8000_0001, 0, 1));
    rows.push_back(cfg_row(tnsgd_pkg::REG_INITIAL_WEIGHT, 16'h7FFF));
    rows.push_back(word_row(tnsgd_pkg::OP_FILL, '0, 0, 0));
    rows.push_back(typed_row(tnsgd_pkg::OP_PREDICT, '1, 0, 16'sd32767, 1, 0));
    rows.push_back(word_row(tnsgd_pkg::OP_TRAIN, '1, 0, 1));
    rows.push_back(cfg_row(tnsgd_pkg::REG_INITIAL_WEIGHT, 16'h8000));
    rows.push_back(word_row(tnsgd_pkg::OP_FILL, '1, 1, 1));
    rows.push_back(typed_row(tnsgd_pkg::OP_PREDICT, '1, 1, -16'sd32767, 0, 0));
    rows.push_back(word_row(tnsgd_pkg::OP_TRAIN, '1, 1, 1));
    rows.push_back(cfg_row(tnsgd_pkg::REG_INITIAL_WEIGHT, 16'h0100));
    rows.push_back(word_row(tnsgd_pkg::OP_PREDICT, 32'h0F0F_0F0F, 0, 0));
    rows.push_back(word_row(tnsgd_pkg::OP_FILL, '0, 0, 0));
    rows.push_back(word_row(tnsgd_pkg::OP_PREDICT, 32'h0000_0007, 1, 1));
    rows.push_back(cfg_row(tnsgd_pkg::REG_LEARNING_RATE, 16'h0000));
    rows.push_back(word_row(tnsgd_pkg::OP_TRAIN, 32'h0000_00FF, 0, 1));
    rows.push_back(cfg_row(tnsgd_pkg::REG_LEARNING_RATE, 16'h7FFF));
    rows.push_back(word_row(tnsgd_pkg::OP_TRAIN, 32'h0000_00FF, 0, 1));
    rows.push_back(word_row(tnsgd_pkg::OP_PREDICT, 32'h0000_00FF, 0, 1));
    rows.push_back(cfg_row(tnsgd_pkg::REG_LEARNING_RATE, 16'(tnsgd_pkg::LR_RESET)));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].reg_sel, rows[i].wdata);
      else send_word(rows[i].op, rows[i].bits, rows[i].lbl, rows[i].last,
                     rows[i].typed, rows[i].res);
    end

    // more chunks than the store holds, extra ones ignored
    for (int c = 0; c < NCHUNK + 3; c++)
      send_word(tnsgd_pkg::OP_PREDICT, rand_bits(), 0, c == NCHUNK + 2);
    for (int c = 0; c < NCHUNK + 1; c++)
      send_word(c % 2 ? tnsgd_pkg::OP_TRAIN : tnsgd_pkg::OP_PREDICT, rand_bits(), 1,
                c == NCHUNK);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: write_reg(tnsgd_pkg::REG_LEARNING_RATE, 16'h7FFF);
        1: write_reg(tnsgd_pkg::REG_LEARNING_RATE, 16'h0000);
        default: write_reg(tnsgd_pkg::REG_LEARNING_RATE, 16'($urandom_range(0, 32767)));
      endcase
      case (ph % 5)
        0: write_reg(tnsgd_pkg::REG_INITIAL_WEIGHT, 16'h8000);
        1: write_reg(tnsgd_pkg::REG_INITIAL_WEIGHT, 16'h7FFF);
        2: write_reg(tnsgd_pkg::REG_INITIAL_WEIGHT, 16'h0000);
        default: write_reg(tnsgd_pkg::REG_INITIAL_WEIGHT,
                           16'($urandom_range(0, 1200)) - 16'd600);
      endcase
      if ($urandom_range(0, 4) != 0) send_word(tnsgd_pkg::OP_FILL, rand_bits(), 0, 0);
      while (words_sent < 60 + (ph + 1) * 165) begin
        case ($urandom_range(0, 39))
          0: n = $urandom_range(NCHUNK - 1, NCHUNK + 3);
          1, 2, 3, 4: n = $urandom_range(5, 20);
          default: n = $urandom_range(1, 4);
        endcase
        op = $urandom_range(0, 1) ? tnsgd_pkg::OP_TRAIN : tnsgd_pkg::OP_PREDICT;
        lbl = $urandom_range(0, 1);
        for (int c = 0; c < n; c++) begin
          if ($urandom_range(0, 24) == 0)
            send_word(tnsgd_pkg::OP_NONE, $urandom(), $urandom_range(0, 1),
                      $urandom_range(0, 1));
          if ($urandom_range(0, 59) == 0) begin
            send_word(tnsgd_pkg::OP_FILL, $urandom(), $urandom_range(0, 1),
                      $urandom_range(0, 1));
            break;
          end
          send_word(c == n - 1 ? op : tnsgd_pkg::opcode_t'($urandom_range(0, 1)),
                    rand_bits(), $urandom_range(0, 1), 1'b0);
        end
        send_word(op, rand_bits(), lbl, 1);
      end
    end

    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/tnsgd_pkg.sv
rtl/tnsgd_lane.sv
rtl/tnsgd_merge.sv
rtl/tnsgd_tanh_rom.sv
rtl/tanh_neuron_sgd_trainer.sv
bench/tb.sv
